// ===== hdl/fbc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package fbc_pkg;

    localparam int COEF_W   = 16;
    localparam int OFS_W    = 32;
    localparam int POS_W    = 24;
    localparam int EDGE_W   = 16;
    localparam int IDX_W    = 3;
    // corner coordinate carries one extra bit for pos +/- edge
    localparam int CRN_W    = POS_W + 1;
    localparam int PROD_W   = COEF_W + CRN_W;
    // offset Q24.8 aligned to the .22 point of the products
    localparam int OFS_SH   = 14;
    localparam int SUM_W    = 48;

    localparam int QUEUE_DEPTH = 2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TEST = 1'b1;

    typedef struct packed {
        logic                     is_test;
        logic                     load_ok;
        logic [IDX_W-1:0]         idx;
        logic signed [COEF_W-1:0] coef_a;
        logic signed [COEF_W-1:0] coef_b;
        logic signed [COEF_W-1:0] coef_c;
        logic signed [OFS_W-1:0]  coef_d;
        logic signed [CRN_W-1:0]  lo_x;
        logic signed [CRN_W-1:0]  lo_y;
        logic signed [CRN_W-1:0]  lo_z;
        logic signed [CRN_W-1:0]  hi_x;
        logic signed [CRN_W-1:0]  hi_y;
        logic signed [CRN_W-1:0]  hi_z;
    } t_item;

endpackage
`default_nettype wire

// ===== hdl/frustum_box_cull_core.sv =====
// frustum_box_cull_core: culls axis-aligned cubes against PLANE_COUNT stored planes
//
// input channel (i_in_valid / o_in_ready): one request per accepted beat.
//   i_cmd = load writes plane i_plane_index (indexes past the store are dropped),
//   no result. i_cmd = test gives a cube by lowest corner + full edge, or by
//   centre + half edge (i_centred), and yields one o_visible result.
// output channel (o_out_valid / i_out_ready): o_visible = 0 when some plane has
//   all eight corners at or behind it, else 1.
// a front stage registers each request and forms the cube's low/high corners,
// a two-entry queue follows, and the back end owns the plane store.
// a test passes through the front register, the queue, the back end's eval state
//   (one plane per cycle: three 16x25 multipliers, then a 48-bit sum), its wait
//   and done states and the output register; the back end takes no new request
//   until that result is in the output register, and applies loads while idle.
// reset clears the plane store to zero, so a test before any load is culled.
// when the receiver stalls, the result holds in the output register; the back
// end keeps applying loads and evaluating the next test, and the queue and
// front stage then fill before o_in_ready drops.
`timescale 1ns / 1ps
`default_nettype none
module frustum_box_cull_core
    import fbc_pkg::*;
#(
    parameter int PLANE_COUNT = 6
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic                     i_cmd,
    input  wire logic [IDX_W-1:0]         i_plane_index,
    input  wire logic signed [COEF_W-1:0] i_coef_a,
    input  wire logic signed [COEF_W-1:0] i_coef_b,
    input  wire logic signed [COEF_W-1:0] i_coef_c,
    input  wire logic signed [OFS_W-1:0]  i_coef_d,
    input  wire logic signed [POS_W-1:0]  i_pos_x,
    input  wire logic signed [POS_W-1:0]  i_pos_y,
    input  wire logic signed [POS_W-1:0]  i_pos_z,
    input  wire logic [EDGE_W-1:0]        i_edge_req,
    input  wire logic                     i_centred,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic                          o_visible
);

    logic  f_valid;
    logic  f_ready;
    t_item f_item;
    logic  q_valid;
    logic  q_ready;
    t_item q_item;

    fbc_front #(
        .PLANE_COUNT (PLANE_COUNT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cmd         (i_cmd),
        .i_plane_index (i_plane_index),
        .i_coef_a      (i_coef_a),
        .i_coef_b      (i_coef_b),
        .i_coef_c      (i_coef_c),
        .i_coef_d      (i_coef_d),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_edge_req    (i_edge_req),
        .i_centred     (i_centred),
        .o_q_valid     (f_valid),
        .o_q_item      (f_item),
        .i_q_ready     (f_ready)
    );

    fbc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_item  (f_item),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_item   (q_item)
    );

    fbc_back #(
        .PLANE_COUNT (PLANE_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_q_ready   (q_ready),
        .i_q_item    (q_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_visible   (o_visible)
    );

endmodule
`default_nettype wire

// ===== hdl/fbc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module fbc_front
    import fbc_pkg::*;
#(
    parameter int PLANE_COUNT = 6
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic                     i_cmd,
    input  wire logic [IDX_W-1:0]         i_plane_index,
    input  wire logic signed [COEF_W-1:0] i_coef_a,
    input  wire logic signed [COEF_W-1:0] i_coef_b,
    input  wire logic signed [COEF_W-1:0] i_coef_c,
    input  wire logic signed [OFS_W-1:0]  i_coef_d,
    input  wire logic signed [POS_W-1:0]  i_pos_x,
    input  wire logic signed [POS_W-1:0]  i_pos_y,
    input  wire logic signed [POS_W-1:0]  i_pos_z,
    input  wire logic [EDGE_W-1:0]        i_edge_req,
    input  wire logic                     i_centred,
    output logic                          o_q_valid,
    output t_item                         o_q_item,
    input  wire logic                     i_q_ready
);

    logic                    r_valid;
    t_item                   r_item;
    t_item                   n_item;
    logic signed [CRN_W-1:0] edge_s;
    logic signed [CRN_W-1:0] px;
    logic signed [CRN_W-1:0] py;
    logic signed [CRN_W-1:0] pz;

    assign edge_s = $signed({{(CRN_W-EDGE_W){1'b0}}, i_edge_req});
    assign px     = CRN_W'(i_pos_x);
    assign py     = CRN_W'(i_pos_y);
    assign pz     = CRN_W'(i_pos_z);

    always_comb begin
        n_item         = '0;
        n_item.is_test = (i_cmd == CMD_TEST);
        n_item.load_ok = (32'(i_plane_index) < PLANE_COUNT);
        n_item.idx     = i_plane_index;
        n_item.coef_a  = i_coef_a;
        n_item.coef_b  = i_coef_b;
        n_item.coef_c  = i_coef_c;
        n_item.coef_d  = i_coef_d;
        // centre mode spans pos - half .. pos + half
        n_item.lo_x    = i_centred ? (px - edge_s) : px;
        n_item.lo_y    = i_centred ? (py - edge_s) : py;
        n_item.lo_z    = i_centred ? (pz - edge_s) : pz;
        n_item.hi_x    = px + edge_s;
        n_item.hi_y    = py + edge_s;
        n_item.hi_z    = pz + edge_s;
    end

    assign o_in_ready = !r_valid || i_q_ready;
    assign o_q_valid  = r_valid;
    assign o_q_item   = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
        if (i_in_valid && o_in_ready) begin
            r_item <= n_item;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/fbc_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module fbc_queue
    import fbc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push_valid,
    output logic       o_push_ready,
    input  wire t_item i_push_item,
    output logic       o_pop_valid,
    input  wire logic  i_pop_ready,
    output t_item      o_pop_item
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_item           r_mem [QUEUE_DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            push;
    logic            pop;

    assign o_push_ready = (r_count != CW'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/fbc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module fbc_back
    import fbc_pkg::*;
#(
    parameter int PLANE_COUNT = 6
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_q_valid,
    output logic       o_q_ready,
    input  wire t_item i_q_item,
    output logic       o_out_valid,
    input  wire logic  i_out_ready,
    output logic       o_visible
);

    localparam int IW = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_WAIT,
        S_DONE
    } t_state;

    t_state                   r_state;
    logic signed [COEF_W-1:0] r_na [PLANE_COUNT];
    logic signed [COEF_W-1:0] r_nb [PLANE_COUNT];
    logic signed [COEF_W-1:0] r_nc [PLANE_COUNT];
    logic signed [OFS_W-1:0]  r_nd [PLANE_COUNT];
    t_item                    r_cube;
    logic [IW-1:0]            r_plane;
    logic                     r_s1_valid;
    logic signed [PROD_W-1:0] r_pa;
    logic signed [PROD_W-1:0] r_pb;
    logic signed [PROD_W-1:0] r_pc;
    logic signed [OFS_W-1:0]  r_pd;
    logic                     r_culled;
    logic                     r_out_valid;
    logic                     r_visible;

    logic signed [COEF_W-1:0] ca;
    logic signed [COEF_W-1:0] cb;
    logic signed [COEF_W-1:0] cc;
    logic signed [CRN_W-1:0]  sx;
    logic signed [CRN_W-1:0]  sy;
    logic signed [CRN_W-1:0]  sz;
    logic signed [PROD_W-1:0] pa;
    logic signed [PROD_W-1:0] pb;
    logic signed [PROD_W-1:0] pc;
    logic signed [SUM_W-1:0]  sum;
    logic                     n_culled;
    logic                     n_out_valid;
    logic                     out_free;
    logic                     last_plane;

    assign ca = r_na[r_plane];
    assign cb = r_nb[r_plane];
    assign cc = r_nc[r_plane];

    // the corner farthest along the normal gives the largest s
    assign sx = ca[COEF_W-1] ? r_cube.lo_x : r_cube.hi_x;
    assign sy = cb[COEF_W-1] ? r_cube.lo_y : r_cube.hi_y;
    assign sz = cc[COEF_W-1] ? r_cube.lo_z : r_cube.hi_z;
    assign pa = ca * sx;
    assign pb = cb * sy;
    assign pc = cc * sz;

    assign sum = SUM_W'(r_pa) + SUM_W'(r_pb) + SUM_W'(r_pc)
               + SUM_W'($signed({r_pd, {OFS_SH{1'b0}}}));
    // cleared while idle so each test starts fresh
    assign n_culled    = (r_state == S_IDLE) ? 1'b0
                       : (r_culled || (r_s1_valid && (sum <= 0)));
    assign out_free    = !r_out_valid || i_out_ready;
    assign n_out_valid = ((r_state == S_DONE) && out_free) || (r_out_valid && !i_out_ready);
    assign last_plane  = (r_plane == IW'(PLANE_COUNT - 1));

    assign o_q_ready   = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_visible   = r_visible;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_plane     <= '0;
            r_s1_valid  <= 1'b0;
            r_culled    <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < PLANE_COUNT; i++) begin
                r_na[i] <= '0;
                r_nb[i] <= '0;
                r_nc[i] <= '0;
                r_nd[i] <= '0;
            end
        end else begin
            r_out_valid <= n_out_valid;
            r_s1_valid  <= (r_state == S_EVAL);
            r_culled    <= n_culled;
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        if (i_q_item.is_test) begin
                            r_cube   <= i_q_item;
                            r_plane  <= '0;
                            r_state  <= S_EVAL;
                        end else if (i_q_item.load_ok) begin
                            for (int i = 0; i < PLANE_COUNT; i++) begin
                                if (32'(i_q_item.idx) == i) begin
                                    r_na[i] <= i_q_item.coef_a;
                                    r_nb[i] <= i_q_item.coef_b;
                                    r_nc[i] <= i_q_item.coef_c;
                                    r_nd[i] <= i_q_item.coef_d;
                                end
                            end
                        end
                    end
                end
                S_EVAL: begin
                    r_pa       <= pa;
                    r_pb       <= pb;
                    r_pc       <= pc;
                    r_pd       <= r_nd[r_plane];
                    if (last_plane) begin
                        r_state <= S_WAIT;
                    end else begin
                        r_plane <= r_plane + 1'b1;
                    end
                end
                S_WAIT: begin
                    // last plane's sum folds into r_culled this cycle
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_visible   <= !r_culled;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire
